>>> rtl/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types, widths and constants of the Prewitt gradient magnitude block.
// ----------------------------------------------------------------------------
package pgm_pkg;

   localparam int PIX_W     = 8;
   localparam int GRAD_W    = 11;
   localparam int SQ_W      = 20;
   localparam int SUM_W     = 21;
   localparam int ROOT_IN_W = 16;
   localparam int ROOT_ST_W = ROOT_IN_W + 2;
   localparam int ROOT_STEPS = ROOT_IN_W / 4;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_LVL_W   = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   // Starting weights of the upper and lower halves of the square root.
   localparam logic [ROOT_ST_W-1:0] ROOT_ONE_HI = ROOT_ST_W'(1) << (ROOT_IN_W - 2);
   localparam logic [ROOT_ST_W-1:0] ROOT_ONE_LO = ROOT_ST_W'(1) << (ROOT_IN_W / 2 - 2);

   // One queued gradient pair with its position marks.
   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     row_end;
      logic                     frame_end;
   } pgm_grad_type;

   // Partial square root: the remainder and the root built so far.
   typedef struct packed {
      logic [ROOT_ST_W-1:0] op;
      logic [ROOT_ST_W-1:0] res;
   } pgm_root_type;

   // Half of an integer square root of a 16-bit value: four result bits,
   // starting at the given weight.
   function automatic pgm_root_type isqrt_half(input pgm_root_type st_in,
                                               input logic [ROOT_ST_W-1:0] one_in);
      pgm_root_type         st;
      logic [ROOT_ST_W-1:0] one;
      logic [ROOT_ST_W-1:0] t;
      st  = st_in;
      one = one_in;
      for (int i = 0; i < ROOT_STEPS; i++) begin
         t = st.res + one;
         if (st.op >= t) begin
            st.op  = st.op - t;
            st.res = (st.res >> 1) + one;
         end else begin
            st.res = st.res >> 1;
         end
         one = one >> 2;
      end
      return st;
   endfunction

endpackage

>>> rtl/prewitt_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// prewitt_gradient_magnitude
// Streaming 3x3 Prewitt edge magnitude over raster-order 8-bit pixels.
//
//   channel   ports                                      direction
//   req       req_valid, req_stall, req_pixel            in
//   rsp       rsp_valid, rsp_stall, rsp_magnitude,
//             rsp_row_end, rsp_frame_end                 out
//   csr       csr_wen, csr_index, csr_wdata              in
//
// One pixel is taken per cycle when the result side keeps up; the pixel that
// completes a window passes the second-stage registers, the queue and the four back stages before its result appears.
// The two line stores are block memories with one read and one write a cycle
// and need no clearing after reset; reset clears positions, window and queue.
// A stall on the result side fills the four-entry queue, then stalls input.
// A write to the width or height register restarts the frame at the top left pixel.
// ----------------------------------------------------------------------------
module prewitt_gradient_magnitude #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pgm_pkg::PIX_W-1:0]         req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pgm_pkg::PIX_W-1:0]         rsp_magnitude,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  logic                              csr_wen,
   input  logic [pgm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pgm_pkg::CFG_W-1:0]         csr_wdata
);
   import pgm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WIDTH_RST  = 640;
   localparam int HEIGHT_RST = 480;
   localparam int WIDTH_LAST_RST  = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;
   localparam int HEIGHT_LAST_RST = ((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST) - 1;

   logic [CW-1:0] width_last_ff, width_last_in;
   logic [RW-1:0] height_last_ff, height_last_in;
   logic [13:0]   wdata_ext;
   logic          restart;

   logic          push, pop, q_valid;
   pgm_grad_type  push_data, q_data;
   logic [Q_LVL_W-1:0] q_level;

   assign wdata_ext = {2'b00, csr_wdata};
   assign restart   = csr_wen && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));

   // Registers hold the clamped dimension minus one.
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_WIDTH: begin
               if (wdata_ext < 14'd3) begin
                  width_last_in = CW'(2);
               end else if (wdata_ext > 14'(MAX_WIDTH)) begin
                  width_last_in = CW'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = CW'(wdata_ext - 14'd1);
               end
            end
            REG_HEIGHT: begin
               if (wdata_ext < 14'd3) begin
                  height_last_in = RW'(2);
               end else if (wdata_ext > 14'(MAX_HEIGHT)) begin
                  height_last_in = RW'(MAX_HEIGHT - 1);
               end else begin
                  height_last_in = RW'(wdata_ext - 14'd1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= CW'(WIDTH_LAST_RST);
         height_last_ff <= RW'(HEIGHT_LAST_RST);
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
      end
   end

   pgm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel   (req_pixel),
      .restart     (restart),
      .width_last  (width_last_ff),
      .height_last (height_last_ff),
      .q_level     (q_level),
      .push        (push),
      .push_data   (push_data)
   );

   pgm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .level     (q_level)
   );

   pgm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> rtl/pgm_front.sv
// ----------------------------------------------------------------------------
// pgm_front
// Accepts pixels, tracks the raster position, keeps the two line stores and
// the window columns, and queues the gradient pair of every interior pixel.
// ----------------------------------------------------------------------------
module pgm_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pgm_pkg::PIX_W-1:0]           req_pixel,
   input  logic                                restart,
   input  logic [$clog2(MAX_WIDTH)-1:0]        width_last,
   input  logic [$clog2(MAX_HEIGHT)-1:0]       height_last,
   input  logic [pgm_pkg::Q_LVL_W-1:0]         q_level,
   output logic                                push,
   output pgm_pkg::pgm_grad_type               push_data
);
   import pgm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] prev2_mem [MAX_WIDTH];

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             accept;
   logic [Q_LVL_W:0] occupancy;

   // Second stage: registered store reads and the item's flags.
   logic             b_valid_ff;
   logic             b_emit_ff;
   logic             b_row_end_ff;
   logic             b_frame_end_ff;
   logic [CW-1:0]    b_addr_ff;
   logic [PIX_W-1:0] b_px_ff;
   logic [PIX_W-1:0] b_top_ff;
   logic [PIX_W-1:0] b_mid_ff;

   logic [PIX_W-1:0] win_ff [6];

   logic             row_end;
   logic [PIX_W+1:0] sum_left, sum_right, sum_up, sum_down;

   // The queue must have room for the item in the second stage and a new one.
   assign occupancy = {1'b0, q_level} + (Q_LVL_W+1)'(b_valid_ff);
   assign req_stall = occupancy >= (Q_LVL_W+1)'(Q_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign row_end   = (col_ff == width_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff >= width_last) begin
            col_in = '0;
            row_in = (row_ff >= height_last) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_emit_ff      <= (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         b_row_end_ff   <= row_end;
         b_frame_end_ff <= row_end && (row_ff == height_last);
         b_addr_ff      <= col_ff;
         b_px_ff        <= req_pixel;
      end
   end

   // Row above: read old value and write the new pixel at the same column.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_mid_ff         <= prev_mem[col_ff];
         prev_mem[col_ff] <= req_pixel;
      end
   end

   // Two rows above: the old middle value lands here in the cycle after accept.
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         prev2_mem[b_addr_ff] <= b_mid_ff;
      end
      if (accept) begin
         b_top_ff <= prev2_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (b_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= b_top_ff;
         win_ff[4] <= b_mid_ff;
         win_ff[5] <= b_px_ff;
      end
   end

   assign sum_left  = {2'b00, win_ff[0]} + {2'b00, win_ff[1]} + {2'b00, win_ff[2]};
   assign sum_right = {2'b00, b_top_ff} + {2'b00, b_mid_ff} + {2'b00, b_px_ff};
   assign sum_up    = {2'b00, win_ff[0]} + {2'b00, win_ff[3]} + {2'b00, b_top_ff};
   assign sum_down  = {2'b00, win_ff[2]} + {2'b00, win_ff[5]} + {2'b00, b_px_ff};

   assign push                = b_valid_ff && b_emit_ff;
   assign push_data.gx        = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
   assign push_data.gy        = $signed({1'b0, sum_down}) - $signed({1'b0, sum_up});
   assign push_data.row_end   = b_row_end_ff;
   assign push_data.frame_end = b_frame_end_ff;

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (Q_LVL_W+1)'(Q_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_second_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted item did not reach the second stage");

endmodule

>>> rtl/pgm_queue.sv
// ----------------------------------------------------------------------------
// pgm_queue
// Short first-in first-out queue of gradient pairs between the front and
// back parts.
// ----------------------------------------------------------------------------
module pgm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pgm_pkg::pgm_grad_type        push_data,
   input  logic                         pop,
   output logic                         pop_valid,
   output pgm_pkg::pgm_grad_type        pop_data,
   output logic [pgm_pkg::Q_LVL_W-1:0]  level
);
   import pgm_pkg::*;

   pgm_grad_type       entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_LVL_W-1:0] count_ff;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         count_ff <= count_ff + Q_LVL_W'(push) - Q_LVL_W'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != Q_LVL_W'(Q_DEPTH)))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from an empty queue");

endmodule

>>> rtl/pgm_back.sv
// ----------------------------------------------------------------------------
// pgm_back
// Four-stage pipeline: squares the gradients, sums and saturates, then takes
// the integer square root over two stages into the result register.
// ----------------------------------------------------------------------------
module pgm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  pgm_pkg::pgm_grad_type        q_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pgm_pkg::PIX_W-1:0]    rsp_magnitude,
   output logic                         rsp_row_end,
   output logic                         rsp_frame_end
);
   import pgm_pkg::*;

   logic signed [2*GRAD_W-1:0] sq_x_full, sq_y_full;
   logic [SUM_W-1:0]           sum;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 en1, en2, en3, en4;
   logic [SQ_W-1:0]      sq_x_ff, sq_y_ff;
   logic                 re1_ff, fe1_ff;
   logic                 sat_ff;
   logic [ROOT_IN_W-1:0] sum_ff;
   logic                 re2_ff, fe2_ff;
   pgm_root_type         root_init, root_lo;
   pgm_root_type         root_ff;
   logic                 sat3_ff;
   logic                 re3_ff, fe3_ff;
   logic [PIX_W-1:0]     mag_ff;
   logic                 re4_ff, fe4_ff;

   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign pop = q_valid && en1;

   assign sq_x_full = q_data.gx * q_data.gx;
   assign sq_y_full = q_data.gy * q_data.gy;
   assign sum       = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   assign root_init.op  = {2'b00, sum_ff};
   assign root_init.res = '0;
   assign root_lo       = isqrt_half(root_ff, ROOT_ONE_LO);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= q_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sq_x_ff <= sq_x_full[SQ_W-1:0];
         sq_y_ff <= sq_y_full[SQ_W-1:0];
         re1_ff  <= q_data.row_end;
         fe1_ff  <= q_data.frame_end;
      end
      if (en2) begin
         sat_ff <= |sum[SUM_W-1:ROOT_IN_W];
         sum_ff <= sum[ROOT_IN_W-1:0];
         re2_ff <= re1_ff;
         fe2_ff <= fe1_ff;
      end
      if (en3) begin
         root_ff <= isqrt_half(root_init, ROOT_ONE_HI);
         sat3_ff <= sat_ff;
         re3_ff  <= re2_ff;
         fe3_ff  <= fe2_ff;
      end
      if (en4) begin
         mag_ff <= sat3_ff ? MAG_MAX : root_lo.res[PIX_W-1:0];
         re4_ff <= re3_ff;
         fe4_ff <= fe3_ff;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_row_end   = re4_ff;
   assign rsp_frame_end = fe4_ff;

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && fe4_ff) |-> re4_ff)
      else $error("frame end marked without row end");

endmodule
